// ----- rtl/core/nmf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nmf_pkg
// Shared types, codes and helpers for the sentence framer: parse phases,
// action and status codes, framing characters and the hex digit decoder.
// ----------------------------------------------------------------------------
package nmf_pkg;

    // Default payload capacity in bytes.
    localparam int NMF_PAYLOAD_DEPTH = 64;

    // Framing characters.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    // Marker returned by the hex decoder for a byte that is not a hex digit.
    localparam logic [4:0] HEX_BAD = 5'h10;

    // Parse phase of the sentence in progress.
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_DATA  = 2'd1,
        PH_HEX1  = 2'd2,
        PH_HEX2  = 2'd3
    } phase_t;

    // Input word actions.
    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_READ    = 2'd2
    } act_t;

    // Result word status codes.
    typedef enum logic [2:0] {
        ST_TAKEN    = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_IGNORED  = 3'd3,
        ST_BADHEX   = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_READ     = 3'd6
    } status_t;

    // Result of one word as it leaves the control stage. The read data
    // itself arrives from the registered payload memory in the next cycle.
    typedef struct packed {
        status_t    status;
        logic       frame_ready;
        logic [6:0] frame_length;
        logic       rd_hit;
        logic [7:0] checksum;
    } res_info_t;

    // Decode one ASCII hex digit; HEX_BAD for anything else.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        begin
            d = 8'h00;
            r = HEX_BAD;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
                r = {1'b0, d[3:0]};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
                r = {1'b0, d[3:0]};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
                r = {1'b0, d[3:0]};
            end
            return r;
        end
    endfunction

endpackage : nmf_pkg
`default_nettype wire

// ----- rtl/core/nmf_payload_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nmf_payload_ram
// Payload byte store: one write port and one read port, read data
// registered. Contents are undefined after reset.
// ----------------------------------------------------------------------------
module nmf_payload_ram
    import nmf_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = NMF_PAYLOAD_DEPTH,
    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem_reg [PAYLOAD_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : nmf_payload_ram
`default_nettype wire

// ----- rtl/core/nmf_frame_ctl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nmf_frame_ctl
// Sentence parser: tracks the framing phase, the running XOR, the payload
// count and the held sentence, issues payload writes and reads to the
// store, and forms the status of every accepted word.
// ----------------------------------------------------------------------------
module nmf_frame_ctl
    import nmf_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = NMF_PAYLOAD_DEPTH,
    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1,
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic [1:0]    action,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [5:0]    read_index,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_data,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    output res_info_t          info
);

    phase_t        phase_reg, phase_next;
    logic          holding_reg, holding_next;
    logic [CW-1:0] count_reg, count_next;
    logic          overflow_reg, overflow_next;
    logic [7:0]    run_xor_reg, run_xor_next;
    logic [7:0]    rx_xor_reg, rx_xor_next;
    logic [CW-1:0] held_reg, held_next;

    act_t          act;
    logic          byte_go;
    logic [4:0]    hex;
    logic          hex_ok;
    logic          is_dollar;
    logic          is_star;
    logic          data_byte;
    logic          store_ok;
    logic [7:0]    rx_full;
    status_t       status;
    logic [CW+5:0] idx_ext;
    logic [CW+5:0] held_ext;
    logic [AW+5:0] addr_ext;
    logic [CW+6:0] len_ext;
    logic          rd_hit;

    // Decode of the incoming word.
    assign act       = act_t'(action);
    assign byte_go   = in_fire && (act == ACT_BYTE) && !holding_reg;
    assign hex       = hex_value(rx_byte);
    assign hex_ok    = (hex != HEX_BAD);
    assign is_dollar = (rx_byte == CH_DOLLAR);
    assign is_star   = (rx_byte == CH_STAR);
    assign data_byte = byte_go && (phase_reg == PH_DATA) && !is_dollar && !is_star;
    assign store_ok  = (count_reg < CW'(PAYLOAD_DEPTH));
    assign rx_full   = rx_xor_reg | {4'h0, hex[3:0]};

    // Next framing phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (byte_go)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (is_dollar)
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (is_star)
                    begin
                        phase_next = PH_HEX1;
                    end
                end
                PH_HEX1:
                begin
                    if (hex_ok)
                    begin
                        phase_next = PH_HEX2;
                    end
                    else if (is_dollar)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                PH_HEX2:
                begin
                    if (is_dollar)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    // Datapath updates and status of the word.
    always_comb
    begin
        holding_next  = holding_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        run_xor_next  = run_xor_reg;
        rx_xor_next   = rx_xor_reg;
        held_next     = held_reg;
        status        = ST_TAKEN;

        if (in_fire)
        begin
            case (act)
                ACT_BYTE:
                begin
                    if (holding_reg)
                    begin
                        status = ST_IGNORED;
                    end
                    else if (is_dollar)
                    begin
                        // A start mark restarts the sentence in every phase.
                        count_next    = '0;
                        run_xor_next  = 8'h00;
                        overflow_next = 1'b0;
                        if (phase_reg == PH_HEX1 || phase_reg == PH_HEX2)
                        begin
                            status = ST_BADHEX;
                        end
                    end
                    else if (phase_reg == PH_DATA)
                    begin
                        if (!is_star)
                        begin
                            run_xor_next = run_xor_reg ^ rx_byte;
                            if (store_ok)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                                status        = ST_OVERFLOW;
                            end
                        end
                    end
                    else if (phase_reg == PH_HEX1)
                    begin
                        if (hex_ok)
                        begin
                            rx_xor_next = {hex[3:0], 4'h0};
                        end
                        else
                        begin
                            status = ST_BADHEX;
                        end
                    end
                    else if (phase_reg == PH_HEX2)
                    begin
                        if (!hex_ok)
                        begin
                            status = ST_BADHEX;
                        end
                        else
                        begin
                            rx_xor_next = rx_full;
                            if (overflow_reg)
                            begin
                                status = ST_OVERFLOW;
                            end
                            else if (rx_full != run_xor_reg)
                            begin
                                status = ST_MISMATCH;
                            end
                            else
                            begin
                                status       = ST_ACCEPT;
                                holding_next = 1'b1;
                                held_next    = count_reg;
                            end
                        end
                    end
                end
                ACT_RELEASE:
                begin
                    holding_next = 1'b0;
                    held_next    = '0;
                end
                ACT_READ:
                begin
                    status = ST_READ;
                end
                default:
                begin
                    status = ST_TAKEN;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            holding_reg  <= 1'b0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            run_xor_reg  <= 8'h00;
            rx_xor_reg   <= 8'h00;
            held_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            holding_reg  <= holding_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            run_xor_reg  <= run_xor_next;
            rx_xor_reg   <= rx_xor_next;
            held_reg     <= held_next;
        end
    end

    // Payload store write: one byte per data character while room is left.
    assign wr_en   = data_byte && store_ok;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = rx_byte;

    // Payload store read. Writes happen only while nothing is held and reads
    // return data only while a sentence is held, so the two never collide.
    assign idx_ext  = {{CW{1'b0}}, read_index};
    assign held_ext = {6'b0, held_reg};
    assign addr_ext = {{AW{1'b0}}, read_index};
    assign rd_hit   = holding_reg && (idx_ext < held_ext)
                      && (idx_ext < (CW+6)'(PAYLOAD_DEPTH));
    assign rd_en    = in_fire && (act == ACT_READ);
    assign rd_addr  = addr_ext[AW-1:0];

    // Result of the word, seen after its own update.
    assign len_ext = {7'b0, (holding_next ? held_next : {CW{1'b0}})};

    always_comb
    begin
        info.status       = status;
        info.frame_ready  = holding_next;
        info.frame_length = len_ext[6:0];
        info.rd_hit       = rd_hit && (act == ACT_READ);
        info.checksum     = run_xor_next;
    end

    // While a sentence is held the parser stays waiting for a start mark.
    a_hold_phase: assert property (@(posedge clk) disable iff (!rst_n)
        holding_reg |-> (phase_reg == PH_START))
        else $error("sentence held outside the start phase");

    // The payload count never runs past the store capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(PAYLOAD_DEPTH))
        else $error("payload count beyond capacity");

    // The store is never written while a held sentence may be read.
    a_no_write_held: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !holding_reg)
        else $error("payload write while a sentence is held");

    // A held length exists only together with a held sentence.
    a_held_len: assert property (@(posedge clk) disable iff (!rst_n)
        !holding_reg |-> (held_reg == '0))
        else $error("held length without a held sentence");

endmodule : nmf_frame_ctl
`default_nettype wire

// ----- rtl/core/nmf_result_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nmf_result_reg
// Two-stage result path: a stage that waits for the payload memory read
// data, then the output register that holds a word while the consumer
// stalls. Stage one moves on only when the output register can take its word.
// ----------------------------------------------------------------------------
module nmf_result_reg
    import nmf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire res_info_t  info,
    input  wire logic [7:0] mem_data,
    output logic            load_ok,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic            frame_ready,
    output logic [6:0]      frame_length,
    output logic [7:0]      read_data,
    output logic [7:0]      checksum_seen
);

    logic      s1_valid_reg, s1_valid_next;
    res_info_t s1_info_reg;
    logic      out_valid_reg, out_valid_next;
    res_info_t out_info_reg;
    logic [7:0] out_data_reg;
    logic      advance;

    // Stage one moves into the output register when that register is free.
    assign advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign load_ok = !s1_valid_reg || advance;

    // Valid flags of both stages.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of both stages; read data comes from memory during stage one.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_info_reg <= info;
        end
        if (advance)
        begin
            out_info_reg <= s1_info_reg;
            out_data_reg <= s1_info_reg.rd_hit ? mem_data : 8'h00;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_info_reg.status;
    assign frame_ready   = out_info_reg.frame_ready;
    assign frame_length  = out_info_reg.frame_length;
    assign read_data     = out_data_reg;
    assign checksum_seen = out_info_reg.checksum;

    // A new word is never loaded over one that cannot move on.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> !load)
        else $error("stage one overwritten while stalled");

    // Nothing held means no length is reported.
    a_len_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_info_reg.frame_ready) |-> (out_info_reg.frame_length == 7'd0))
        else $error("frame length without a held sentence");

    // Read data is only ever nonzero on a read result.
    a_data_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_info_reg.status != ST_READ) |-> (out_data_reg == 8'h00))
        else $error("read data on a non-read result");

endmodule : nmf_result_reg
`default_nettype wire

// ----- rtl/core/nmea_sentence_framer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// Frames '$' payload '*' hex hex sentences from a byte stream, checks the
// XOR checksum, holds an accepted sentence and serves reads of its bytes.
// ----------------------------------------------------------------------------
// Result words are registered in stage one with the payload memory read
// data, then in the output stage. Throughput: one word per cycle while
// in_stall is low (raised while stage one holds a word that cannot move on);
// the parser updates its state and the memory takes one access per word.
// Reset: rst_n clears the parse state, held sentence and pipeline valids at
// once; the payload memory is not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module nmea_sentence_framer
    import nmf_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = NMF_PAYLOAD_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] action,
    input  wire logic [7:0] rx_byte,
    input  wire logic [5:0] read_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic            frame_ready,
    output logic [6:0]      frame_length,
    output logic [7:0]      read_data,
    output logic [7:0]      checksum_seen
);

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    logic          in_fire;
    logic          load_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    mem_data;
    res_info_t     info;

    // Input handshake.
    assign in_stall = !load_ok;
    assign in_fire  = in_valid && load_ok;

    nmf_frame_ctl #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .action     (action),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .info       (info)
    );

    nmf_payload_ram #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mem_data)
    );

    nmf_result_reg u_res (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_fire),
        .info          (info),
        .mem_data      (mem_data),
        .load_ok       (load_ok),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .frame_ready   (frame_ready),
        .frame_length  (frame_length),
        .read_data     (read_data),
        .checksum_seen (checksum_seen)
    );

endmodule : nmea_sentence_framer
`default_nettype wire

// ----- tb/sv/nmea_frame_monitor.sv -----
// ----------------------------------------------------------------------------
// nmea_frame_monitor
// Watches both word channels of the sentence framer. Every accepted input
// word runs through a bit-accurate model of the parser, and its predicted
// result is queued. Every accepted result word is compared field by field
// with the oldest queued prediction. Mismatch and pending counts go to the
// testbench top.
// ----------------------------------------------------------------------------
module nmea_frame_monitor
    import nmf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [1:0] action,
    input  wire logic [7:0] rx_byte,
    input  wire logic [5:0] read_index,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [2:0] status,
    input  wire logic       frame_ready,
    input  wire logic [6:0] frame_length,
    input  wire logic [7:0] read_data,
    input  wire logic [7:0] checksum_seen,
    output int              mismatches,
    output int              results_owed
);

    // One predicted result word.
    typedef struct packed {
        status_t    status;
        logic       frame_ready;
        logic [6:0] frame_length;
        logic [7:0] read_data;
        logic [7:0] checksum;
    } frame_result_t;

    // Model state of the parser.
    phase_t     stage;
    logic       holding;
    logic [6:0] fill;
    logic       spilled;
    logic [7:0] sum_run;
    logic [7:0] sum_rx;
    logic [6:0] held_len;
    logic [7:0] payload_mem [0:NMF_PAYLOAD_DEPTH-1];

    frame_result_t pending_results [$];
    int            results_seen;

    // Value of an ASCII hex digit, with bit 4 set for any other character.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, c[3:0]};
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    // A start mark opens a fresh payload.
    function automatic void open_sentence();
        stage   = PH_DATA;
        fill    = 7'd0;
        sum_run = 8'h00;
        spilled = 1'b0;
    endfunction

    // Advance the model by one input word and return the result it causes.
    function automatic frame_result_t frame_result(input logic [1:0] act,
                                                   input logic [7:0] ch,
                                                   input logic [5:0] ix);
        frame_result_t r;
        logic [4:0]    h;
        r.status    = ST_TAKEN;
        r.read_data = 8'h00;
        h           = nibble_of(ch);
        if (act == ACT_BYTE && holding)
        begin
            r.status = ST_IGNORED;
        end
        else if (act == ACT_BYTE)
        begin
            case (stage)
                PH_START:
                begin
                    if (ch == CH_DOLLAR)
                        open_sentence();
                end
                PH_DATA:
                begin
                    if (ch == CH_DOLLAR)
                        open_sentence();
                    else if (ch == CH_STAR)
                        stage = PH_HEX1;
                    else
                    begin
                        sum_run = sum_run ^ ch;
                        if (fill < 7'(NMF_PAYLOAD_DEPTH))
                        begin
                            payload_mem[fill[5:0]] = ch;
                            fill = fill + 7'd1;
                        end
                        else
                        begin
                            spilled  = 1'b1;
                            r.status = ST_OVERFLOW;
                        end
                    end
                end
                default:
                begin
                    // Either hex digit: a bad one abandons the sentence,
                    // unless it is a start mark.
                    if (h[4])
                    begin
                        if (ch == CH_DOLLAR)
                            open_sentence();
                        else
                            stage = PH_START;
                        r.status = ST_BADHEX;
                    end
                    else if (stage == PH_HEX1)
                    begin
                        sum_rx = {h[3:0], 4'h0};
                        stage  = PH_HEX2;
                    end
                    else
                    begin
                        sum_rx = sum_rx | {4'h0, h[3:0]};
                        stage  = PH_START;
                        if (spilled)
                            r.status = ST_OVERFLOW;
                        else if (sum_rx != sum_run)
                            r.status = ST_MISMATCH;
                        else
                        begin
                            holding  = 1'b1;
                            held_len = fill;
                            r.status = ST_ACCEPT;
                        end
                    end
                end
            endcase
        end
        else if (act == ACT_RELEASE)
        begin
            holding  = 1'b0;
            held_len = 7'd0;
        end
        else if (act == ACT_READ)
        begin
            r.status = ST_READ;
            if (holding && {1'b0, ix} < held_len)
                r.read_data = payload_mem[ix];
        end
        r.frame_ready  = holding;
        r.frame_length = holding ? held_len : 7'd0;
        r.checksum     = sum_run;
        return r;
    endfunction

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what, input int seen_val,
                                   input int want_val);
        $display("result %0d: %s is %0d, predicted %0d",
                 results_seen, what, seen_val, want_val);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t want;
        if (!rst_n)
        begin
            stage        = PH_START;
            holding      = 1'b0;
            fill         = 7'd0;
            spilled      = 1'b0;
            sum_run      = 8'h00;
            sum_rx       = 8'h00;
            held_len     = 7'd0;
            results_seen = 0;
            mismatches   = 0;
            pending_results.delete();
            results_owed <= 0;
        end
        else
        begin
            // Compare a delivered result word with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("status of a result with none pending", status, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (frame_ready !== want.frame_ready)
                        report_mismatch("frame_ready", frame_ready, want.frame_ready);
                    if (frame_length !== want.frame_length)
                        report_mismatch("frame_length", frame_length, want.frame_length);
                    if (read_data !== want.read_data)
                        report_mismatch("read_data", read_data, want.read_data);
                    if (checksum_seen !== want.checksum)
                        report_mismatch("checksum_seen", checksum_seen, want.checksum);
                end
            end
            // Predict the result of an accepted input word.
            if (in_valid && !in_stall)
                pending_results.push_back(frame_result(action, rx_byte, read_index));
            results_owed <= pending_results.size();
        end
    end

endmodule : nmea_frame_monitor

// ----- tb/sv/tb_nmea_sentence_framer.sv -----
// ----------------------------------------------------------------------------
// tb_nmea_sentence_framer
// Drives the sentence framer with a directed opening (held, mismatched and
// broken sentences, reads and releases) followed by random well-formed,
// corrupted, overlong and broken sentences mixed with noise words, under
// three patterns of sender and receiver idling. The monitor beside the block
// does all checking; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_framer;
    import nmf_pkg::*;

    // Action code that the block has no use for.
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [1:0] action     = ACT_BYTE;
    logic [7:0] rx_byte    = 8'h00;
    logic [5:0] read_index = 6'd0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [2:0] status;
    logic       frame_ready;
    logic [6:0] frame_length;
    logic [7:0] read_data;
    logic [7:0] checksum_seen;

    int mismatches;
    int results_owed;
    int in_gap_pct  = 6;
    int out_gap_pct = 63;
    int words_sent  = 0;

    nmea_sentence_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .rx_byte       (rx_byte),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .frame_ready   (frame_ready),
        .frame_length  (frame_length),
        .read_data     (read_data),
        .checksum_seen (checksum_seen)
    );

    nmea_frame_monitor monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .rx_byte       (rx_byte),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .frame_ready   (frame_ready),
        .frame_length  (frame_length),
        .read_data     (read_data),
        .checksum_seen (checksum_seen),
        .mismatches    (mismatches),
        .results_owed  (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The receiver stalls at random.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < out_gap_pct);
    end

    // Offer one word, after optional idle cycles, and wait until it is taken.
    task automatic send_word(input logic [1:0] act, input logic [7:0] ch,
                             input logic [5:0] ix);
        while ($urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        rx_byte    <= ch;
        read_index <= ix;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_word(ACT_BYTE, ch, 6'($urandom));
    endtask

    // Hold off the sender until every result is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Hex digit for a nibble, letters in either case.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        base = ($urandom_range(1) != 0) ? 8'h41 : 8'h61;
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return base + {4'h0, n} - 8'd10;
    endfunction

    // Payload character: mostly printable, never a framing character.
    function automatic logic [7:0] payload_char();
        logic [7:0] c;
        do
        begin
            c = ($urandom_range(99) < 75) ? 8'($urandom_range(8'h7e, 8'h20))
                                          : 8'($urandom);
        end
        while (c == CH_DOLLAR || c == CH_STAR);
        return c;
    endfunction

    // Random traffic until the given number of further words is sent.
    task automatic random_phase(input int goal);
        int         stop;
        int         pick;
        int         n;
        int         cut;
        int         k;
        logic [7:0] sum;
        logic [7:0] c;
        stop = words_sent + goal;
        while (words_sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                // Sentence, mostly well-formed, short as a rule, now and then long
                // enough to reach or pass the store's capacity.
                if (pick < 55)
                    n = $urandom_range(12);
                else if ($urandom_range(1) != 0)
                    n = $urandom_range(63, 13);
                else
                    n = $urandom_range(70, 63);
                cut = ($urandom_range(99) < 8) ? $urandom_range(n) : -1;
                sum = 8'h00;
                send_char(CH_DOLLAR);
                for (k = 0; k < n; k++)
                begin
                    // A start mark inside the payload begins it again.
                    if (k == cut)
                    begin
                        send_char(CH_DOLLAR);
                        sum = 8'h00;
                    end
                    c   = payload_char();
                    sum = sum ^ c;
                    send_char(c);
                end
                send_char(CH_STAR);
                if ($urandom_range(99) < 15)
                    sum = sum ^ (8'h01 << $urandom_range(7));
                send_char(hex_char(sum[7:4]));
                send_char(hex_char(sum[3:0]));
                // Poke at the held sentence, then usually let it go.
                repeat ($urandom_range(3))
                    send_word(ACT_READ, 8'($urandom),
                              ($urandom_range(1) != 0) ?
                              6'($urandom_range((n > 63) ? 63 : n)) : 6'($urandom));
                if ($urandom_range(3) == 0)
                    send_char(8'($urandom));
                if ($urandom_range(99) < 85)
                    send_word(ACT_RELEASE, 8'($urandom), 6'($urandom));
            end
            else if (pick < 80)
            begin
                // Sentence broken by a character that is not a hex digit.
                send_char(CH_DOLLAR);
                repeat ($urandom_range(4))
                    send_char(payload_char());
                send_char(CH_STAR);
                if ($urandom_range(1) != 0)
                    send_char(hex_char(4'($urandom)));
                case ($urandom_range(2))
                    0:       send_char(8'($urandom_range(8'h2f)));
                    1:       send_char(8'($urandom_range(8'hff, 8'h67)));
                    default: send_char(8'($urandom_range(8'h5a, 8'h47)));
                endcase
            end
            else
            begin
                // Noise: any action, any byte, any index.
                repeat ($urandom_range(4, 1))
                    send_word(2'($urandom), 8'($urandom), 6'($urandom));
            end
            if ($urandom_range(99) < 2)
                drain_results();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: stray byte, unused action, release and read
        // with nothing held.
        send_char("A");
        send_word(ACT_SPARE, 8'hff, 6'h3f);
        send_word(ACT_RELEASE, 8'h00, 6'h00);
        send_word(ACT_READ, 8'h00, 6'h00);
        // Sentence with extreme payload bytes and a lowercase checksum digit.
        send_char(CH_DOLLAR);
        send_char(8'h00);
        send_char(8'hff);
        send_char("a");
        send_char(CH_STAR);
        send_char("9");
        send_char("e");
        // Held: a byte is ignored, reads inside and past the payload.
        send_char(8'h55);
        send_word(ACT_READ, 8'h00, 6'd1);
        send_word(ACT_READ, 8'hff, 6'd63);
        send_word(ACT_RELEASE, 8'hff, 6'h3f);
        // Empty sentence with a wrong checksum.
        send_char(CH_DOLLAR);
        send_char(CH_STAR);
        send_char("0");
        send_char("A");
        // Start mark as first hex digit, then a bad second hex digit.
        send_char(CH_DOLLAR);
        send_char(CH_STAR);
        send_char(CH_DOLLAR);
        send_char(CH_STAR);
        send_char("1");
        send_char("z");

        random_phase(234);
        drain_results();

        in_gap_pct  = 63;
        out_gap_pct = 6;
        random_phase(233);
        drain_results();

        in_gap_pct  = 0;
        out_gap_pct = 0;
        random_phase(233);
        drain_results();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("nmea_sentence_framer regression: pass");
        else
            $display("nmea_sentence_framer regression: fail");
        $finish;
    end

    // Give up if the run hangs.
    initial
    begin
        #4000000;
        $display("nmea_sentence_framer regression: fail");
        $finish;
    end

endmodule : tb_nmea_sentence_framer

// ----- sim.f -----
rtl/core/nmf_pkg.sv
rtl/core/nmf_payload_ram.sv
rtl/core/nmf_frame_ctl.sv
rtl/core/nmf_result_reg.sv
rtl/core/nmea_sentence_framer.sv
tb/sv/nmea_frame_monitor.sv
tb/sv/tb_nmea_sentence_framer.sv
